[src/bgsf_pkg.sv]
// ----------------------------------------------------------------------------
// bgsf_pkg: shared types and constants for the bus gain smoothstep fader
// Command codes, controller states, datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package bgsf_pkg;
    localparam int BUS_COUNT = 8;
    localparam int BUS_W     = $clog2(BUS_COUNT);
    localparam int LINK_W    = 24;

    localparam logic [16:0] UNITY     = 17'd32768;
    localparam logic [16:0] POS_ONE   = 17'd65536;
    localparam logic [16:0] CLOCK_MAX = 17'd131071;

    typedef enum logic [2:0] {
        CMD_SET_VOLUME = 3'd0,
        CMD_SET_MUTE   = 3'd1,
        CMD_FADE_TO    = 3'd2,
        CMD_ADVANCE    = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_ADV_LOAD,
        ST_ADV_DIV,
        ST_ADV_SQ,
        ST_ADV_CUBE,
        ST_ADV_MIX,
        ST_ADV_WRITE,
        ST_CHAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic apply;      // perform set volume / mute / fade on addressed bus
        logic adv_load;   // load bus under adv_idx, add ticks
        logic div_start;
        logic adv_sq;
        logic adv_cube;
        logic adv_mix;
        logic adv_write;
        logic adv_next;
        logic chain_init;
        logic chain_step;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic adv_skip;   // current bus not fading
        logic adv_last;
        logic chain_done;
    } dp_status_t;
endpackage
`default_nettype wire

[src/bgsf_ctrl.sv]
// ----------------------------------------------------------------------------
// bgsf_ctrl: command sequencer
// Steps the datapath through apply, advance-time sweep and chain walk.
// ----------------------------------------------------------------------------
`default_nettype none
module bgsf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic               is_advance,
    input  wire logic               out_free,
    input  wire bgsf_pkg::dp_status_t status,
    output bgsf_pkg::dp_cmd_t       cmd,
    output logic                    busy
);
    import bgsf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = is_advance ? ST_ADV_LOAD : ST_APPLY;
            ST_APPLY:     state_next = ST_CHAIN;
            ST_ADV_LOAD:  state_next = ST_ADV_DIV;
            ST_ADV_DIV: begin
                if (status.adv_skip) begin
                    state_next = status.adv_last ? ST_CHAIN : ST_ADV_LOAD;
                end else if (!status.div_busy) begin
                    state_next = ST_ADV_SQ;
                end
            end
            ST_ADV_SQ:    state_next = ST_ADV_CUBE;
            ST_ADV_CUBE:  state_next = ST_ADV_MIX;
            ST_ADV_MIX:   state_next = ST_ADV_WRITE;
            ST_ADV_WRITE: state_next = status.adv_last ? ST_CHAIN : ST_ADV_LOAD;
            ST_CHAIN:     if (status.chain_done) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                cmd.chain_init = start & ~is_advance;
            end
            ST_APPLY:     cmd.apply = 1'b1;
            ST_ADV_LOAD: begin
                cmd.adv_load  = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_ADV_DIV: begin
                cmd.adv_next   = status.adv_skip;
                cmd.chain_init = status.adv_skip & status.adv_last;
            end
            ST_ADV_SQ:    cmd.adv_sq = 1'b1;
            ST_ADV_CUBE:  cmd.adv_cube = 1'b1;
            ST_ADV_MIX:   cmd.adv_mix = 1'b1;
            ST_ADV_WRITE: begin
                cmd.adv_write  = 1'b1;
                cmd.adv_next   = 1'b1;
                cmd.chain_init = status.adv_last;
            end
            ST_CHAIN:     cmd.chain_step = 1'b1;
            ST_DONE:      cmd.result_load = out_free;
            default:      busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

[src/bgsf_div.sv]
// ----------------------------------------------------------------------------
// bgsf_div: restoring divider
// Computes min(clock*65536/span, 65536), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bgsf_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [16:0] clock,
    input  wire logic [15:0] span,
    output logic             busy,
    output logic [16:0]      quot
);
    import bgsf_pkg::*;

    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [17:0] trial;

    // clock < span on entry, so 16 quotient bits suffice; the other case is
    // forced to POS_ONE.
    assign trial = {rem_reg, 1'b0} - {2'b00, span};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        if (start) begin
            if (span == 16'd0 || clock >= {1'b0, span}) begin
                q_next   = POS_ONE;
                cnt_next = '0;
            end else begin
                rem_next = clock;
                q_next   = '0;
                cnt_next = 5'd16;
            end
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 5'd1;
            if (!trial[17]) begin
                rem_next = trial[16:0];
                q_next   = {q_reg[15:0], 1'b1};
            end else begin
                rem_next = {rem_reg[15:0], 1'b0};
                q_next   = {q_reg[15:0], 1'b0};
            end
        end
    end

    assign busy = start | (cnt_reg != '0);
    assign quot = q_reg;
endmodule
`default_nettype wire

[src/bgsf_datapath.sv]
// ----------------------------------------------------------------------------
// bgsf_datapath: bus state, fade arithmetic and chain product
// Holds per-bus registers; runs smoothstep and the parent-chain multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module bgsf_datapath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bgsf_pkg::dp_cmd_t     cmd,
    output bgsf_pkg::dp_status_t       status,
    input  wire logic                  in_take,
    input  wire logic [2:0]            in_command,
    input  wire logic [2:0]            in_bus,
    input  wire logic [15:0]           in_gain,
    input  wire logic                  in_mute,
    input  wire logic [15:0]           in_len,
    input  wire logic [15:0]           in_ticks,
    input  wire logic [bgsf_pkg::LINK_W-1:0] parent_links,
    output logic [15:0]                res_volume,
    output logic [15:0]                res_gain,
    output logic                       res_muted,
    output logic                       res_fading
);
    import bgsf_pkg::*;

    logic [16:0] vol_reg   [BUS_COUNT];
    logic        mute_reg  [BUS_COUNT];
    logic        fade_reg  [BUS_COUNT];
    logic [16:0] start_reg [BUS_COUNT];
    logic [16:0] tgt_reg   [BUS_COUNT];
    logic [15:0] span_reg  [BUS_COUNT];
    logic [16:0] clk_reg   [BUS_COUNT];

    logic [2:0]  cmd_reg;
    logic [2:0]  bus_reg;
    logic [16:0] gain_reg;
    logic        mflag_reg;
    logic [15:0] len_reg;
    logic [15:0] ticks_reg;

    logic [BUS_W-1:0] adv_idx_reg;
    logic [16:0] aclk_val_reg;   // saturated new clock of current bus
    logic [16:0] t_sq_reg;       // t, the divider quotient
    logic [33:0] tt_reg;
    logic [16:0] s_reg;
    logic [16:0] mix_reg;

    logic        div_busy;
    logic [16:0] div_q;

    logic [BUS_W-1:0] cur_reg;
    logic [16:0] acc_reg;
    logic [3:0]  walk_reg;
    logic        chain_done_reg;
    logic        zero_reg;

    logic        bus_ok;
    logic [BUS_W-1:0] bidx;
    logic [17:0] clk_sum;
    logic [16:0] clk_sat;
    logic [BUS_W-1:0] par;
    logic [2:0]  pfield;
    logic [33:0] prod;
    logic [18:0] three_m;
    logic [50:0] cube;
    logic [33:0] mixa;
    logic [33:0] mixb;
    logic [34:0] mixs;

    assign bus_ok = ({1'b0, bus_reg} < 4'(BUS_COUNT));
    assign bidx   = bus_reg[BUS_W-1:0];

    assign clk_sum = {1'b0, clk_reg[adv_idx_reg]} + {2'b00, ticks_reg};
    assign clk_sat = clk_sum[17] ? CLOCK_MAX : clk_sum[16:0];

    bgsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .clock   (clk_sat),
        .span    (span_reg[adv_idx_reg]),
        .busy    (div_busy),
        .quot    (div_q)
    );

    assign status.div_busy   = div_busy;
    assign status.adv_skip   = ~fade_reg[adv_idx_reg];
    assign status.adv_last   = (adv_idx_reg == BUS_W'(BUS_COUNT - 1));
    assign status.chain_done = chain_done_reg;

    // parent lookup of the bus being walked
    always_comb begin
        pfield = parent_links[3*cur_reg +: 3];
        if (cur_reg == '0 || ({1'b0, pfield} >= 4'(BUS_COUNT))) begin
            par = '0;
        end else begin
            par = pfield[BUS_W-1:0];
        end
    end

    assign prod    = {17'd0, acc_reg} * {17'd0, vol_reg[cur_reg]};
    assign three_m = 19'(3 * 65536) - {1'b0, t_sq_reg, 1'b0};
    assign cube    = {17'd0, tt_reg} * {32'd0, three_m};
    assign mixa    = {17'd0, start_reg[adv_idx_reg]} * {17'd0, POS_ONE - s_reg};
    assign mixb    = {17'd0, tgt_reg[adv_idx_reg]} * {17'd0, s_reg};
    assign mixs    = {1'b0, mixa} + {1'b0, mixb} + 35'd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUS_COUNT; i++) begin
                vol_reg[i]   <= UNITY;
                mute_reg[i]  <= 1'b0;
                fade_reg[i]  <= 1'b0;
                start_reg[i] <= '0;
                tgt_reg[i]   <= '0;
                span_reg[i]  <= '0;
                clk_reg[i]   <= '0;
            end
            adv_idx_reg    <= '0;
            chain_done_reg <= 1'b0;
        end else begin
            if (in_take) begin
                cmd_reg   <= in_command;
                bus_reg   <= in_bus;
                gain_reg  <= (in_gain > 16'd32768) ? UNITY : {1'b0, in_gain};
                mflag_reg <= in_mute;
                len_reg   <= in_len;
                ticks_reg <= in_ticks;
                adv_idx_reg <= '0;
            end
            if (cmd.apply && bus_ok) begin
                unique case (cmd_reg)
                    CMD_SET_VOLUME: vol_reg[bidx] <= gain_reg;
                    CMD_SET_MUTE:   mute_reg[bidx] <= mflag_reg;
                    CMD_FADE_TO: begin
                        if (len_reg == 16'd0) begin
                            vol_reg[bidx]  <= gain_reg;
                            fade_reg[bidx] <= 1'b0;
                        end else begin
                            start_reg[bidx] <= vol_reg[bidx];
                            tgt_reg[bidx]   <= gain_reg;
                            span_reg[bidx]  <= len_reg;
                            clk_reg[bidx]   <= '0;
                            fade_reg[bidx]  <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.adv_load && fade_reg[adv_idx_reg]) begin
                clk_reg[adv_idx_reg] <= clk_sat;
                aclk_val_reg <= clk_sat;
            end
            if (cmd.adv_sq) begin
                t_sq_reg <= div_q;
                tt_reg   <= {17'd0, div_q} * {17'd0, div_q};
            end
            if (cmd.adv_cube) begin
                s_reg <= cube[48:32];
            end
            if (cmd.adv_mix) begin
                mix_reg <= mixs[32:16];
            end
            if (cmd.adv_write) begin
                if (aclk_val_reg >= {1'b0, span_reg[adv_idx_reg]}) begin
                    vol_reg[adv_idx_reg]  <= tgt_reg[adv_idx_reg];
                    fade_reg[adv_idx_reg] <= 1'b0;
                end else begin
                    vol_reg[adv_idx_reg] <= mix_reg;
                end
            end
            if (cmd.adv_next && !status.adv_last) begin
                adv_idx_reg <= adv_idx_reg + 1'b1;
            end
            if (cmd.chain_init) begin
                chain_done_reg <= 1'b0;
            end else if (cmd.chain_step) begin
                if (!bus_ok || zero_reg || mute_reg[cur_reg] || cur_reg == '0
                    || walk_reg == 4'(BUS_COUNT - 1)) begin
                    chain_done_reg <= 1'b1;
                end
            end
        end
    end

    // chain walk: one bus per cycle
    always_ff @(posedge aclk) begin
        if (cmd.chain_init) begin
            cur_reg  <= (cmd.apply | in_take) ? in_bus[BUS_W-1:0] : bidx;
            acc_reg  <= UNITY;
            walk_reg <= '0;
            zero_reg <= 1'b0;
        end else if (cmd.chain_step && !chain_done_reg && !zero_reg) begin
            if (mute_reg[cur_reg]) begin
                zero_reg <= 1'b1;
            end else begin
                acc_reg  <= 17'((prod + 34'd16384) >> 15);
                cur_reg  <= par;
                walk_reg <= walk_reg + 4'd1;
            end
        end
        if (cmd.result_load) begin
            if (bus_ok) begin
                res_volume <= vol_reg[bidx][15:0];
                res_gain   <= zero_reg ? 16'd0 : acc_reg[15:0];
                res_muted  <= mute_reg[bidx];
                res_fading <= fade_reg[bidx];
            end else begin
                res_volume <= '0;
                res_gain   <= '0;
                res_muted  <= 1'b0;
                res_fading <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[src/bus_gain_smoothstep_fader_unit.sv]
// ----------------------------------------------------------------------------
// bus_gain_smoothstep_fader_unit: gain bus bank with smoothstep fades
// Stream command in, one bus status result out; APB parent-link register.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_axis  | in        | command, bus, gain, mute, fade length, ticks
//  m_axis  | out       | bus volume, effective gain, muted, fading
//  apb     | in        | parent_links at address 0
// One command at a time. A non-advance result is loaded after an apply state,
// the one-bus-per-cycle chain walk and an output state; the next command is
// accepted once the unit is back in idle.
// Advance time replaces the apply state by a sweep: a fading bus passes load,
// the bit-serial divider, square, cube, mix and write; an idle bus is skipped.
// Reset is synchronous; buses come up at unity. A stalled result holds in the
// output register; the next command is taken and runs until its result is ready.
`default_nettype none
module bus_gain_smoothstep_fader_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] command, [5:3] bus_index, [21:6] gain_value, [22] mute_flag,
    // [38:23] fade_length, [54:39] elapsed_ticks
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] bus_volume, [31:16] effective_gain, [32] is_muted, [33] is_fading
    output logic [39:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bgsf_pkg::*;

    logic [LINK_W-1:0] links_reg;
    logic        busy;
    logic        take;
    logic        out_free;
    logic        mvalid_reg;
    dp_cmd_t     dcmd;
    dp_status_t  dstat;
    logic [15:0] r_vol, r_gain;
    logic        r_mute, r_fade;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, links_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            links_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) begin
                links_reg <= pwdata[LINK_W-1:0];
            end
            if (dcmd.result_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = ~busy;
    assign take     = s_tvalid & s_tready;
    assign out_free = ~mvalid_reg | m_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'd0, r_fade, r_mute, r_gain, r_vol};

    bgsf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (take),
        .is_advance (s_tdata[2:0] == CMD_ADVANCE),
        .out_free   (out_free),
        .status     (dstat),
        .cmd        (dcmd),
        .busy       (busy)
    );

    bgsf_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dcmd),
        .status       (dstat),
        .in_take      (take),
        .in_command   (s_tdata[2:0]),
        .in_bus       (s_tdata[5:3]),
        .in_gain      (s_tdata[21:6]),
        .in_mute      (s_tdata[22]),
        .in_len       (s_tdata[38:23]),
        .in_ticks     (s_tdata[54:39]),
        .parent_links (links_reg),
        .res_volume   (r_vol),
        .res_gain     (r_gain),
        .res_muted    (r_mute),
        .res_fading   (r_fade)
    );
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for bus_gain_smoothstep_fader_unit
// Directed table then random commands; results compared against a local
// model of the gain bus bank, with random idling, stalls and link changes.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import bgsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        logic [15:0] ticks;
        logic [15:0] length;
        logic        mute;
        logic [15:0] gain;
        logic [2:0]  bus;
        logic [2:0]  cmd;
    } fader_cmd_t;

    typedef struct packed {
        logic        fading;
        logic        muted;
        logic [15:0] eff_gain;
        logic [15:0] volume;
    } bus_status_t;

    typedef struct {
        fader_cmd_t  c;
        logic        known;
        bus_status_t r;
    } table_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bus_gain_smoothstep_fader_unit i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // model state
    logic [23:0] links;
    logic [15:0] vol      [BUS_COUNT];
    logic        muted    [BUS_COUNT];
    logic        fading   [BUS_COUNT];
    logic [15:0] f_start  [BUS_COUNT];
    logic [15:0] f_target [BUS_COUNT];
    logic [15:0] f_span   [BUS_COUNT];
    logic [16:0] f_clock  [BUS_COUNT];

    bus_status_t expected_status [$];
    int  errors = 0;
    int  idle_pct = 17;
    logic hold_off = 1'b0;
    int  hold_cycles = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
        errors++;
    endtask

    function automatic int parent_bus(input int b);
        int p;
        if (b == 0) return 0;
        p = int'(links[3*b +: 3]);
        return (p < BUS_COUNT) ? p : 0;
    endfunction

    function automatic logic [15:0] chain_gain(input int b);
        logic [31:0] acc;
        int cur;
        acc = 32'd32768;
        cur = b;
        for (int n = 0; n < BUS_COUNT; n++) begin
            if (muted[cur]) return 16'd0;
            acc = (acc * vol[cur] + 32'd16384) >> 15;
            if (cur == 0) break;
            cur = parent_bus(cur);
        end
        return acc[15:0];
    endfunction

    task automatic advance_fade(input int b, input logic [15:0] ticks);
        logic [17:0] clk;
        logic [63:0] t, s, mix;
        if (!fading[b]) return;
        clk = f_clock[b] + ticks;
        if (clk > 18'd131071) clk = 18'd131071;
        f_clock[b] = clk[16:0];
        if (f_span[b] == 0 || clk >= f_span[b]) t = 64'd65536;
        else begin
            t = (64'(clk) << 16) / f_span[b];
            if (t > 65536) t = 64'd65536;
        end
        s = (t * t * (3 * 65536 - 2 * t)) >> 32;
        mix = 64'(f_start[b]) * (65536 - s) + 64'(f_target[b]) * s + 32768;
        vol[b] = mix[31:16];
        if (clk >= f_span[b]) begin
            vol[b] = f_target[b];
            fading[b] = 1'b0;
        end
    endtask

    function automatic void reset_model();
        links = '0;
        for (int i = 0; i < BUS_COUNT; i++) begin
            vol[i] = 16'd32768; muted[i] = 1'b0; fading[i] = 1'b0;
            f_start[i] = '0; f_target[i] = '0; f_span[i] = '0; f_clock[i] = '0;
        end
    endfunction

    task automatic predict_status(input fader_cmd_t c, output bus_status_t r);
        logic [15:0] g;
        int b;
        g = (c.gain > 16'd32768) ? 16'd32768 : c.gain;
        b = c.bus;
        if (c.cmd == CMD_ADVANCE) begin
            for (int i = 0; i < BUS_COUNT; i++) advance_fade(i, c.ticks);
        end else if (c.cmd == CMD_SET_VOLUME) vol[b] = g;
        else if (c.cmd == CMD_SET_MUTE) muted[b] = c.mute;
        else if (c.cmd == CMD_FADE_TO) begin
            if (c.length == 0) begin
                vol[b] = g; fading[b] = 1'b0;
            end else begin
                f_start[b] = vol[b]; f_target[b] = g; f_span[b] = c.length;
                f_clock[b] = '0; fading[b] = 1'b1;
            end
        end
        r.volume = vol[b];
        r.eff_gain = chain_gain(b);
        r.muted = muted[b];
        r.fading = fading[b];
    endtask

    // s_tvalid stays high after an accepted transaction unless the sender idles
    task automatic send_cmd(input fader_cmd_t c, input logic known, input bus_status_t fixed);
        bus_status_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.ticks, c.length, c.mute, c.gain, c.bus, c.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_status(c, r);
        if (known) begin
            if (r != fixed) report("table row", r, fixed);
            expected_status = {expected_status, fixed};
        end else begin
            expected_status = {expected_status, r};
        end
    endtask

    task automatic write_links(input logic [23:0] v);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {8'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        links = v;
    endtask

    function automatic fader_cmd_t rand_cmd();
        fader_cmd_t c;
        int k;
        c.cmd = $urandom_range(99) < 6 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        c.bus = 3'($urandom_range(7));
        k = $urandom_range(9);
        c.gain = k == 0 ? 16'($urandom) : k == 1 ? 16'd32768 : 16'($urandom_range(32768));
        c.mute = $urandom_range(99) < 20;
        k = $urandom_range(9);
        c.length = k == 0 ? 16'($urandom) : k < 3 ? 16'd0 : 16'($urandom_range(1, 300));
        k = $urandom_range(9);
        c.ticks = k == 0 ? 16'($urandom) : 16'($urandom_range(0, 120));
        return c;
    endfunction

    // result checker
    always @(posedge aclk) begin
        bus_status_t got, exp;
        if (m_tvalid && m_tready) begin
            got = m_tdata[33:0];
            if (expected_status.size() == 0) report("unexpected transaction", got, 0);
            else begin
                exp = expected_status.pop_front();
                if (got.volume !== exp.volume) report("bus_volume", got.volume, exp.volume);
                if (got.eff_gain !== exp.eff_gain)
                    report("effective_gain", got.eff_gain, exp.eff_gain);
                if (got.muted !== exp.muted) report("is_muted", got.muted, exp.muted);
                if (got.fading !== exp.fading) report("is_fading", got.fading, exp.fading);
            end
        end
    end

    // receiver with random stalls and an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 600) hold_off <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on accepted transactions
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCHDOG_LIMIT) begin
            $display("FAIL bus_gain_smoothstep_fader_unit");
            $finish;
        end
    end

    table_row_t dir_rows [$];

    function automatic void add_row(input table_row_t t);
        dir_rows = {dir_rows, t};
    endfunction

    function automatic table_row_t row(input logic [2:0] cmd, input logic [2:0] bus,
            input logic [15:0] gain, input logic mute, input logic [15:0] len,
            input logic [15:0] ticks, input logic known, input bus_status_t r);
        table_row_t t;
        t.c = {ticks, len, mute, gain, bus, cmd};
        t.known = known;
        t.r = r;
        return t;
    endfunction

    initial begin
        bus_status_t none;
        none = '0;
        reset_model();
        // known rows: after reset, saturation, zero-length fade, out-of-range command
        add_row(row(CMD_QUERY, 0, 0, 0, 0, 0, 1, {1'b0, 1'b0, 16'd32768, 16'd32768}));
        add_row(row(CMD_SET_VOLUME, 3, 16'hFFFF, 0, 0, 0, 1,
                    {1'b0, 1'b0, 16'd32768, 16'd32768}));
        add_row(row(CMD_SET_VOLUME, 3, 0, 0, 0, 0, 1, {2'b00, 16'd0, 16'd0}));
        add_row(row(CMD_SET_MUTE, 2, 0, 1, 0, 0, 1, {2'b01, 16'd0, 16'd32768}));
        add_row(row(CMD_FADE_TO, 4, 16'd16384, 0, 0, 0, 1,
                    {2'b00, 16'd16384, 16'd16384}));
        add_row(row(3'd7, 5, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1,
                    {2'b00, 16'd32768, 16'd32768}));
        add_row(row(CMD_FADE_TO, 1, 0, 0, 100, 0, 0, none));
        add_row(row(CMD_ADVANCE, 0, 0, 0, 0, 50, 0, none));
        add_row(row(CMD_SET_VOLUME, 1, 16'd20000, 0, 0, 0, 0, none));
        add_row(row(CMD_ADVANCE, 0, 0, 0, 0, 25, 0, none));
        add_row(row(CMD_QUERY, 1, 0, 0, 0, 0, 0, none));
        add_row(row(CMD_ADVANCE, 0, 0, 0, 0, 16'hFFFF, 0, none));
        add_row(row(CMD_FADE_TO, 6, 16'd32768, 0, 16'hFFFF, 0, 0, none));
        add_row(row(CMD_ADVANCE, 0, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 0, none));
        add_row(row(CMD_ADVANCE, 0, 0, 0, 0, 16'hFFFF, 0, none));
        add_row(row(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, none));
        add_row(row(CMD_SET_MUTE, 2, 0, 0, 0, 0, 0, none));
        add_row(row(3'd5, 7, 0, 0, 0, 0, 0, none));
        add_row(row(3'd6, 0, 0, 0, 0, 0, 0, none));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].known, dir_rows[i].r);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_links(24'hFFFFFF);
                1: write_links(24'h000000);
                2: write_links({3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0});
                3: write_links({3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0});
                default: write_links(24'($urandom));
            endcase
            idle_pct = (phase == 2) ? 0 : 17;
            for (int n = 0; n < 300; n++) begin
                if (phase == 1 && n == 50) begin
                    hold_cycles = 0;
                    hold_off = 1'b1;
                end
                if (phase == 4 && n == 150) begin
                    s_tvalid <= 1'b0;
                    while (expected_status.size() != 0) @(posedge aclk);
                end
                send_cmd(rand_cmd(), 0, none);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) $display("PASS bus_gain_smoothstep_fader_unit");
        else $display("FAIL bus_gain_smoothstep_fader_unit");
        $finish;
    end
endmodule
`default_nettype wire
